FILE: rtl/core/mbrx_pkg.sv
package mbrx_pkg;

  // Receive buffer size; length bytes at or above FRAME_BUFFER_BYTES - 2 abort the frame.
  localparam int FRAME_BUFFER_BYTES = 64;
  localparam int LEN_LIMIT_INT      = FRAME_BUFFER_BYTES - 2;
  localparam logic [8:0] LEN_LIMIT  = 9'(LEN_LIMIT_INT);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  EXC_FLAG  = 8'h80;

  localparam logic [7:0] RST_ADDR_PRI  = 8'hFE;
  localparam logic [7:0] RST_ADDR_SEC  = 8'h68;
  localparam logic [7:0] RST_WRITE_FC  = 8'h41;
  localparam logic [7:0] RST_TIMEOUT   = 8'd19;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_ARM  = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ADDR_PRI = 2'd0,
    REG_ADDR_SEC = 2'd1,
    REG_WRITE_FC = 2'd2,
    REG_TIMEOUT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] address_primary;
    logic [7:0] address_secondary;
    logic [7:0] write_code;
    logic [7:0] timeout_limit;
  } cfg_t;

  // One byte through CRC-16/Modbus, bitwise reflected form.
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mbrx_if.sv
interface mbrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [7:0] expected_code;

  modport source (output valid, action, rx_byte, expected_code, input ready);
  modport sink   (input valid, action, rx_byte, expected_code, output ready);
endinterface

interface mbrx_out_if;
  logic       valid;
  logic       ready;
  logic       busy_res;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_done;
  logic       frame_good;
  logic       exception_seen;
  logic [7:0] exception_code;
  logic       timed_out;
  logic       aborted;

  modport source (output valid, busy_res, payload_valid, payload_byte, payload_index,
                  frame_done, frame_good, exception_seen, exception_code, timed_out,
                  aborted, input ready);
  modport sink   (input valid, busy_res, payload_valid, payload_byte, payload_index,
                  frame_done, frame_good, exception_seen, exception_code, timed_out,
                  aborted, output ready);
endinterface

FILE: rtl/core/mbrx_regs.sv
module mbrx_regs
  import mbrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_primary   <= RST_ADDR_PRI;
      cfg_r.address_secondary <= RST_ADDR_SEC;
      cfg_r.write_code        <= RST_WRITE_FC;
      cfg_r.timeout_limit     <= RST_TIMEOUT;
    end else if (wr_en) begin
      case (idx)
        REG_ADDR_PRI: cfg_r.address_primary   <= pwdata[7:0];
        REG_ADDR_SEC: cfg_r.address_secondary <= pwdata[7:0];
        REG_WRITE_FC: cfg_r.write_code        <= pwdata[7:0];
        REG_TIMEOUT:  cfg_r.timeout_limit     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ADDR_PRI: prdata = {24'h0, cfg_r.address_primary};
      REG_ADDR_SEC: prdata = {24'h0, cfg_r.address_secondary};
      REG_WRITE_FC: prdata = {24'h0, cfg_r.write_code};
      REG_TIMEOUT:  prdata = {24'h0, cfg_r.timeout_limit};
      default:      prdata = 32'h0;
    endcase
  end

endmodule

FILE: rtl/core/modbus_rtu_reply_receiver.sv
// Channel | dir | handshake         | word
// in_ch   | in  | valid/ready       | action, rx_byte, expected_code
// out_ch  | out | valid/ready       | status, payload byte/index, CRC and error flags
// cfg     | in  | psel/penable/pwrite, pready tied high | 4 x 8-bit registers
//
// One word in, one word out; an item may enter every cycle while out_ch is not stalled.
// The path is the input register, then receive FSM and CRC step into the output
// register. The byte CRC step fits in that one stage, so one word per cycle unless stalled.
// rst_n is synchronous; it clears the FSM, pipeline valids and config to defaults.
// A stalled out_ch holds its word; the one-word input register fills, then in_ch.ready drops.
module modbus_rtu_reply_receiver
  import mbrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mbrx_in_if.sink     in_ch,
  mbrx_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ADDR, PH_FUNC, PH_EXC, PH_LEN, PH_DATA, PH_CRC0, PH_CRC1
  } phase_t;

  cfg_t cfg;

  mbrx_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_action_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_code_r;
  logic       in_acc;
  logic       proc_en;

  // receiver state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  awaited_r, awaited_nxt;
  logic [7:0]  data_len_r, data_len_nxt;
  logic [7:0]  data_cnt_r, data_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [8:0]  tick_r, tick_nxt;
  logic [7:0]  last_exc_r, last_exc_nxt;
  logic        is_exc_r, is_exc_nxt;

  // result register
  logic       out_valid_r;
  logic       busy_r;
  logic       pv_r, pv_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic [7:0] pi_r, pi_nxt;
  logic       done_r, done_nxt;
  logic       good_r, good_nxt;
  logic       tmo_r, tmo_nxt;
  logic       abrt_r, abrt_nxt;

  logic [15:0] crc_step;
  logic [8:0]  tick_inc;
  logic [7:0]  cnt_inc;
  logic [7:0]  b;

  assign proc_en     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || proc_en;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_ch.action;
      s1_byte_r   <= in_ch.rx_byte;
      s1_code_r   <= in_ch.expected_code;
    end
  end

  assign b        = s1_byte_r;
  assign crc_step = crc16_add(crc_r, b);
  assign tick_inc = tick_r + 9'd1;
  assign cnt_inc  = data_cnt_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    awaited_nxt  = awaited_r;
    data_len_nxt = data_len_r;
    data_cnt_nxt = data_cnt_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    tick_nxt     = tick_r;
    last_exc_nxt = last_exc_r;
    is_exc_nxt   = is_exc_r;
    pv_nxt       = 1'b0;
    pb_nxt       = 8'h00;
    pi_nxt       = 8'h00;
    done_nxt     = 1'b0;
    good_nxt     = 1'b0;
    tmo_nxt      = 1'b0;
    abrt_nxt     = 1'b0;
    case (action_t'(s1_action_r))
      ACT_ARM: begin
        awaited_nxt  = s1_code_r;
        last_exc_nxt = 8'h00;
        is_exc_nxt   = 1'b0;
        tick_nxt     = 9'd0;
        phase_nxt    = PH_ADDR;
      end
      ACT_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_nxt = tick_inc;
          if (tick_inc > {1'b0, cfg.timeout_limit}) begin
            tick_nxt  = 9'd0;
            phase_nxt = PH_IDLE;
            tmo_nxt   = 1'b1;
          end
        end
      end
      ACT_BYTE: begin
        case (phase_r)
          PH_ADDR: begin
            if (b == cfg.address_primary || b == cfg.address_secondary) begin
              data_cnt_nxt = 8'h00;
              crc_nxt      = crc16_add(CRC_INIT, b);
              phase_nxt    = PH_FUNC;
            end
          end
          PH_FUNC: begin
            crc_nxt = crc_step;
            if (b == awaited_r) begin
              data_len_nxt = 8'h00;
              phase_nxt    = (awaited_r == cfg.write_code) ? PH_CRC0 : PH_LEN;
            end else if (b == awaited_r + EXC_FLAG) begin
              phase_nxt = PH_EXC;
            end else begin
              phase_nxt = PH_IDLE;
              abrt_nxt  = 1'b1;
            end
          end
          PH_EXC: begin
            crc_nxt      = crc_step;
            last_exc_nxt = b;
            is_exc_nxt   = 1'b1;
            phase_nxt    = PH_CRC0;
          end
          PH_LEN: begin
            crc_nxt      = crc_step;
            data_len_nxt = b;
            if ({1'b0, b} < LEN_LIMIT) begin
              phase_nxt = (b == 8'h00) ? PH_CRC0 : PH_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              abrt_nxt  = 1'b1;
            end
          end
          PH_DATA: begin
            crc_nxt      = crc_step;
            pv_nxt       = 1'b1;
            pb_nxt       = b;
            pi_nxt       = data_cnt_r;
            data_cnt_nxt = cnt_inc;
            if (cnt_inc == data_len_r) begin
              phase_nxt = PH_CRC0;
            end
          end
          PH_CRC0: begin
            crc_lo_nxt = b;
            phase_nxt  = PH_CRC1;
          end
          PH_CRC1: begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
            good_nxt  = (crc_lo_r == crc_r[7:0]) && (b == crc_r[15:8]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      awaited_r   <= 8'h00;
      data_len_r  <= 8'h00;
      data_cnt_r  <= 8'h00;
      crc_r       <= CRC_INIT;
      crc_lo_r    <= 8'h00;
      tick_r      <= 9'd0;
      last_exc_r  <= 8'h00;
      is_exc_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (proc_en) begin
        phase_r     <= phase_nxt;
        awaited_r   <= awaited_nxt;
        data_len_r  <= data_len_nxt;
        data_cnt_r  <= data_cnt_nxt;
        crc_r       <= crc_nxt;
        crc_lo_r    <= crc_lo_nxt;
        tick_r      <= tick_nxt;
        last_exc_r  <= last_exc_nxt;
        is_exc_r    <= is_exc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a word moves into the output register
  always_ff @(posedge clk) begin
    if (proc_en) begin
      busy_r <= (phase_nxt != PH_IDLE);
      pv_r   <= pv_nxt;
      pb_r   <= pb_nxt;
      pi_r   <= pi_nxt;
      done_r <= done_nxt;
      good_r <= good_nxt;
      tmo_r  <= tmo_nxt;
      abrt_r <= abrt_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.busy_res       = busy_r;
  assign out_ch.payload_valid  = pv_r;
  assign out_ch.payload_byte   = pb_r;
  assign out_ch.payload_index  = pi_r;
  assign out_ch.frame_done     = done_r;
  assign out_ch.frame_good     = good_r;
  assign out_ch.exception_seen = is_exc_r;
  assign out_ch.exception_code = last_exc_r;
  assign out_ch.timed_out      = tmo_r;
  assign out_ch.aborted        = abrt_r;

`ifndef SYNTHESIS
  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (done_r || tmo_r || abrt_r) |-> !busy_r)
    else $error("frame end reported while still busy");

  a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && good_r |-> done_r)
    else $error("frame_good without frame_done");

  a_single_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({done_r, tmo_r, abrt_r, pv_r}) <= 1)
    else $error("more than one frame outcome in one word");

  a_arm_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en && s1_action_r == ACT_ARM |=> phase_r == PH_ADDR && tick_r == 9'd0)
    else $error("arm did not start address hunt");

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r <= 9'd256)
    else $error("tick counter ran past limit");
`endif

endmodule

FILE: test/modbus_rtu_reply_receiver_tb.sv
module modbus_rtu_reply_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;

  localparam int STALL_LIMIT = 500;

  typedef logic [7:0] byte_seq_t[$];

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_HUNT,
    RX_FUNC,
    RX_EXC,
    RX_LEN,
    RX_DATA,
    RX_CRC_LO,
    RX_CRC_HI
  } line_phase_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
    logic [7:0] expected_code;
  } line_word_t;

  typedef struct packed {
    logic       busy_res;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_good;
    logic       exception_seen;
    logic [7:0] exception_code;
    logic       timed_out;
    logic       aborted;
  } reply_status_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbrx_in_if  rx_ch ();
  mbrx_out_if st_ch ();

  modbus_rtu_reply_receiver dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (rx_ch),
    .out_ch  (st_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk = ~clk;

  // receiver model state
  cfg_t        shadow_cfg;
  line_phase_t rx_state;
  logic [7:0]  want_code;
  logic [7:0]  frame_len;
  logic [7:0]  data_seen;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_rx;
  logic [8:0]  ticks_in_frame;
  logic [7:0]  exc_byte;
  logic        exc_flag;

  line_word_t    line_events[$];
  reply_status_t predicted_status[$];
  line_word_t    word_on_line;

  int  words_queued;
  int  words_taken;
  int  mismatches;
  int  src_gap;
  int  snk_gap;
  bit  src_idle_on;
  bit  snk_idle_on;
  int  quiet_cycles;

  int frames_closed;
  int frames_good;
  int payload_total;
  int exception_frames;
  int timeouts;
  int aborts;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        lsb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      lsb = acc[0] ^ data[i];
      acc = {1'b0, acc[15:1]};
      if (lsb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic reply_status_t receiver_step(input line_word_t w);
    reply_status_t r;
    logic [7:0]    b;
    r = '0;
    b = w.rx_byte;
    case (w.action)
      ACT_ARM: begin
        want_code = w.expected_code;
        exc_byte = 8'h00;
        exc_flag = 1'b0;
        ticks_in_frame = 9'd0;
        rx_state = RX_HUNT;
      end
      ACT_TICK: begin
        if (rx_state != RX_IDLE) begin
          ticks_in_frame = ticks_in_frame + 9'd1;
          if (ticks_in_frame > {1'b0, shadow_cfg.timeout_limit}) begin
            ticks_in_frame = 9'd0;
            rx_state = RX_IDLE;
            r.timed_out = 1'b1;
          end
        end
      end
      ACT_BYTE: begin
        case (rx_state)
          RX_HUNT: begin
            if (b == shadow_cfg.address_primary || b == shadow_cfg.address_secondary) begin
              data_seen = 8'h00;
              crc_acc = crc_step(CRC_INIT, b);
              rx_state = RX_FUNC;
            end
          end
          RX_FUNC: begin
            crc_acc = crc_step(crc_acc, b);
            if (b == want_code) begin
              frame_len = 8'h00;
              rx_state = (want_code == shadow_cfg.write_code) ? RX_CRC_LO : RX_LEN;
            end else if (b == 8'(want_code + EXC_FLAG)) begin
              rx_state = RX_EXC;
            end else begin
              rx_state = RX_IDLE;
              r.aborted = 1'b1;
            end
          end
          RX_EXC: begin
            crc_acc = crc_step(crc_acc, b);
            exc_byte = b;
            exc_flag = 1'b1;
            rx_state = RX_CRC_LO;
          end
          RX_LEN: begin
            crc_acc = crc_step(crc_acc, b);
            frame_len = b;
            if (int'(b) < FRAME_BUFFER_BYTES - 2) begin
              rx_state = (b == 8'h00) ? RX_CRC_LO : RX_DATA;
            end else begin
              rx_state = RX_IDLE;
              r.aborted = 1'b1;
            end
          end
          RX_DATA: begin
            crc_acc = crc_step(crc_acc, b);
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = data_seen;
            data_seen = data_seen + 8'h01;
            if (data_seen == frame_len) rx_state = RX_CRC_LO;
          end
          RX_CRC_LO: begin
            crc_lo_rx = b;
            rx_state = RX_CRC_HI;
          end
          RX_CRC_HI: begin
            rx_state = RX_IDLE;
            r.frame_done = 1'b1;
            r.frame_good = (crc_lo_rx == crc_acc[7:0]) && (b == crc_acc[15:8]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.busy_res = (rx_state != RX_IDLE);
    r.exception_seen = exc_flag;
    r.exception_code = exc_byte;

    if (r.frame_done) frames_closed++;
    if (r.frame_good) frames_good++;
    if (r.payload_valid) payload_total++;
    if (r.frame_done && exc_flag) exception_frames++;
    if (r.timed_out) timeouts++;
    if (r.aborted) aborts++;
    return r;
  endfunction

  function automatic void push_word(input action_t act, input logic [7:0] b,
                                    input logic [7:0] code);
    line_word_t w;
    w.action = act;
    w.rx_byte = b;
    w.expected_code = code;
    line_events.push_back(w);
    words_queued++;
  endfunction

  function automatic void append_crc(ref byte_seq_t body, input bit corrupt);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_step(crc, body[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
  endfunction

  // serial bytes with ticks mixed in; burst_at >= 0 puts a full timeout's worth of ticks there
  function automatic void queue_bytes(input byte_seq_t seq, input int tick_pct,
                                      input int burst_at);
    foreach (seq[i]) begin
      if (i == burst_at) begin
        repeat (int'(shadow_cfg.timeout_limit) + 1)
          push_word(ACT_TICK, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(1, 100) <= tick_pct) push_word(ACT_TICK, 8'($urandom), 8'($urandom));
      push_word(ACT_BYTE, seq[i], 8'($urandom));
    end
  endfunction

  function automatic void queue_random_reply();
    byte_seq_t  body;
    logic [7:0] code;
    logic [7:0] fc;
    int         style;
    int         len;
    int         cut;
    int         burst_at;
    bit         closes;
    code = 8'($urandom);
    if ($urandom_range(0, 4) == 0) code = shadow_cfg.write_code;
    push_word(ACT_ARM, 8'($urandom), code);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) push_word(ACT_BYTE, 8'($urandom), 8'($urandom));
    end
    body.push_back($urandom_range(0, 1) ? shadow_cfg.address_primary
                                        : shadow_cfg.address_secondary);
    style = $urandom_range(0, 99);
    closes = 1'b1;
    if (style < 60 || style >= 85) begin
      body.push_back(code);
      if (code != shadow_cfg.write_code) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(FRAME_BUFFER_BYTES - 2, 255);
          1:       len = $urandom_range(7, FRAME_BUFFER_BYTES - 3);
          default: len = $urandom_range(0, 6);
        endcase
        body.push_back(8'(len));
        if (len >= FRAME_BUFFER_BYTES - 2) closes = 1'b0;
        else repeat (len) body.push_back(8'($urandom));
      end
    end else if (style < 75) begin
      body.push_back(code ^ EXC_FLAG);
      body.push_back(8'($urandom));
    end else begin
      do fc = 8'($urandom); while (fc == code || fc == (code ^ EXC_FLAG));
      body.push_back(fc);
      closes = 1'b0;
    end
    if (closes) append_crc(body, style >= 85);
    else if ($urandom_range(0, 1) == 1) body.push_back(8'($urandom));
    // occasionally cut the reply short; the next arm takes over
    if ($urandom_range(0, 24) == 0 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    burst_at = -1;
    if (shadow_cfg.timeout_limit < 8'd64 && $urandom_range(0, 24) == 0)
      burst_at = $urandom_range(0, body.size() - 1);
    queue_bytes(body, 6, burst_at);
    if ($urandom_range(0, 9) == 0) push_word(ACT_TICK, 8'($urandom), 8'($urandom));
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ADDR_PRI: shadow_cfg.address_primary = value;
      REG_ADDR_SEC: shadow_cfg.address_secondary = value;
      REG_WRITE_FC: shadow_cfg.write_code = value;
      REG_TIMEOUT:  shadow_cfg.timeout_limit = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: one word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        predicted_status.push_back(receiver_step(word_on_line));
        words_taken++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          rx_ch.valid <= 1'b0;
        end else if (line_events.size() != 0) begin
          word_on_line = line_events.pop_front();
          rx_ch.valid <= 1'b1;
          rx_ch.action <= word_on_line.action;
          rx_ch.rx_byte <= word_on_line.rx_byte;
          rx_ch.expected_code <= word_on_line.expected_code;
          if (src_idle_on && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 3);
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare every status word
  always @(posedge clk) begin
    if (!rst_n) begin
      st_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (st_ch.valid && st_ch.ready) begin
        if (predicted_status.size() == 0) begin
          $error("status word arrived with nothing predicted");
          mismatches++;
        end else begin
          reply_status_t want;
          want = predicted_status.pop_front();
          check_field("busy_res", want.busy_res, st_ch.busy_res);
          check_field("payload_valid", want.payload_valid, st_ch.payload_valid);
          check_field("payload_byte", want.payload_byte, st_ch.payload_byte);
          check_field("payload_index", want.payload_index, st_ch.payload_index);
          check_field("frame_done", want.frame_done, st_ch.frame_done);
          check_field("frame_good", want.frame_good, st_ch.frame_good);
          check_field("exception_seen", want.exception_seen, st_ch.exception_seen);
          check_field("exception_code", want.exception_code, st_ch.exception_code);
          check_field("timed_out", want.timed_out, st_ch.timed_out);
          check_field("aborted", want.aborted, st_ch.aborted);
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        st_ch.ready <= 1'b0;
      end else begin
        st_ch.ready <= 1'b1;
        if (snk_idle_on && $urandom_range(0, 4) == 0) snk_gap = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (rx_ch.valid && rx_ch.ready) || (st_ch.valid && st_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    byte_seq_t seq;
    cfg_t      next_cfg;

    rst_n = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.action = ACT_BYTE;
    rx_ch.rx_byte = 8'h00;
    rx_ch.expected_code = 8'h00;
    st_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_cycles = 0;

    shadow_cfg.address_primary = RST_ADDR_PRI;
    shadow_cfg.address_secondary = RST_ADDR_SEC;
    shadow_cfg.write_code = RST_WRITE_FC;
    shadow_cfg.timeout_limit = RST_TIMEOUT;
    rx_state = RX_IDLE;
    want_code = 8'h00;
    frame_len = 8'h00;
    data_seen = 8'h00;
    crc_acc = CRC_INIT;
    crc_lo_rx = 8'h00;
    ticks_in_frame = 9'd0;
    exc_byte = 8'h00;
    exc_flag = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle noise, data reply, exception, write reply, both abort kinds
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    push_word(ACT_TICK, 8'h00, 8'h00);
    push_word(ACT_BYTE, 8'hFE, 8'h00);
    push_word(ACT_ARM, 8'h00, 8'h03);
    push_word(ACT_BYTE, 8'h11, 8'hFF);
    seq = '{8'hFE, 8'h03, 8'h02, 8'h00, 8'hFF};
    append_crc(seq, 1'b0);
    queue_bytes(seq, 0, -1);
    push_word(ACT_ARM, 8'hFF, 8'h03);
    seq = '{8'h68, 8'h83, 8'h7F};
    append_crc(seq, 1'b0);
    queue_bytes(seq, 0, -1);
    push_word(ACT_ARM, 8'h00, RST_WRITE_FC);
    seq = '{8'hFE, RST_WRITE_FC};
    append_crc(seq, 1'b0);
    queue_bytes(seq, 0, -1);
    push_word(ACT_ARM, 8'h00, 8'h03);
    seq = '{8'hFE, 8'h05};
    queue_bytes(seq, 0, -1);
    push_word(ACT_ARM, 8'h00, 8'h03);
    seq = '{8'hFE, 8'h03, 8'(FRAME_BUFFER_BYTES - 2)};
    queue_bytes(seq, 0, -1);
    words_queued = words_queued;
    while (line_events.size() < 280) queue_random_reply();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          next_cfg.address_primary = 8'h01;
          next_cfg.address_secondary = 8'h01;
          next_cfg.write_code = 8'h00;
          next_cfg.timeout_limit = 8'h00;
        end
        1: begin
          next_cfg.address_primary = 8'hFF;
          next_cfg.address_secondary = 8'h00;
          next_cfg.write_code = 8'hFF;
          next_cfg.timeout_limit = 8'hFF;
        end
        2: begin
          next_cfg.address_primary = 8'($urandom);
          next_cfg.address_secondary = 8'($urandom);
          next_cfg.write_code = 8'($urandom);
          next_cfg.timeout_limit = 8'($urandom_range(1, 40));
        end
        3: begin
          next_cfg.address_primary = 8'($urandom);
          next_cfg.address_secondary = 8'($urandom);
          next_cfg.write_code = 8'($urandom);
          next_cfg.timeout_limit = 8'($urandom);
        end
        default: begin
          next_cfg.address_primary = 8'h11;
          next_cfg.address_secondary = 8'h22;
          next_cfg.write_code = 8'h06;
          next_cfg.timeout_limit = 8'd19;
        end
      endcase
      write_reg(REG_ADDR_PRI, next_cfg.address_primary);
      write_reg(REG_ADDR_SEC, next_cfg.address_secondary);
      write_reg(REG_WRITE_FC, next_cfg.write_code);
      write_reg(REG_TIMEOUT, next_cfg.timeout_limit);

      if (p == 0) begin
        // zero timeout: first tick in a frame ends it; extreme function codes
        push_word(ACT_ARM, 8'h00, 8'h00);
        push_word(ACT_TICK, 8'hFF, 8'hFF);
        push_word(ACT_ARM, 8'h00, 8'h00);
        seq = '{8'h01, 8'h00};
        append_crc(seq, 1'b0);
        queue_bytes(seq, 0, -1);
        push_word(ACT_ARM, 8'h00, 8'hFF);
        seq = '{8'h01, 8'hFF, 8'h00};
        append_crc(seq, 1'b0);
        queue_bytes(seq, 0, -1);
      end

      if (p == 4) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = $urandom_range(0, 3) != 0;
        snk_idle_on = $urandom_range(0, 3) != 0;
      end
      while (line_events.size() < 250) queue_random_reply();
      wait_drained();
    end

    $display("%0d words over six register settings: %0d frames closed, %0d with good CRC",
             words_taken, frames_closed, frames_good);
    $display("%0d payload bytes, %0d exception replies, %0d timeouts, %0d aborts",
             payload_total, exception_frames, timeouts, aborts);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
